[rtl/ipf_pkg.sv]
// ipf_pkg: shared constants, codes and types of the packet rule filter
// no dependencies; imported by ipf_cfg, ipf_engine and the top level
`timescale 1ns / 1ps

package ipf_pkg;

    // rule table size
    localparam int MAX_RULES = 64;
    localparam int RULE_AW   = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
    localparam int CNT_W     = $clog2(MAX_RULES + 1);

    // protocol numbers and tcp flag bit
    localparam logic [7:0] PROTO_TCP   = 8'd6;
    localparam logic [7:0] PROTO_UDP   = 8'd17;
    localparam int         TCP_SYN_BIT = 1;

    // command codes
    localparam logic [1:0] CMD_ADD      = 2'd0;
    localparam logic [1:0] CMD_CLEAR    = 2'd1;
    localparam logic [1:0] CMD_CLASSIFY = 2'd2;

    // result codes
    localparam logic VERDICT_FORWARD = 1'b0;
    localparam logic VERDICT_DROP    = 1'b1;
    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_FULL     = 1'b1;

    // configuration port: register index is paddr[2]
    localparam int         CFG_AW            = 3;
    localparam logic       REG_FILTER_ENABLE = 1'b0;

    typedef struct packed {
        logic filter_enable;
    } t_cfg;

    typedef struct packed {
        logic [31:0] src_ip;
        logic [31:0] src_mask;
        logic [31:0] dst_ip;
        logic [31:0] dst_mask;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [7:0]  protocol;
        logic        drop;
    } t_rule;

    localparam int RULE_W = $bits(t_rule);

    // packet fields kept for the scan
    typedef struct packed {
        logic [7:0]  protocol;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] src_port;
        logic [15:0] dst_port;
    } t_pkt;

endpackage

[rtl/ipf_if.sv]
// ipf_if: valid/ready channel interfaces for command items and result items
// no dependencies
`timescale 1ns / 1ps

interface ipf_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [7:0]  protocol;
    logic [31:0] src_ip;
    logic [31:0] src_mask;
    logic [31:0] dst_ip;
    logic [31:0] dst_mask;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic        drop_rule;
    logic [7:0]  tcp_flags;

    modport source (
        output valid, command, protocol, src_ip, src_mask, dst_ip, dst_mask,
               src_port, dst_port, drop_rule, tcp_flags,
        input  ready
    );
    modport sink (
        input  valid, command, protocol, src_ip, src_mask, dst_ip, dst_mask,
               src_port, dst_port, drop_rule, tcp_flags,
        output ready
    );
endinterface

interface ipf_out_if;
    logic valid;
    logic ready;
    logic verdict;
    logic status;

    modport source (
        output valid, verdict, status,
        input  ready
    );
    modport sink (
        input  valid, verdict, status,
        output ready
    );
endinterface

[rtl/ipf_ram.sv]
// ipf_ram: generic simple dual-port ram, one write port, one registered read port
// no dependencies
`timescale 1ns / 1ps

module ipf_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/ipf_cfg.sv]
// ipf_cfg: apb register block holding filter_enable
// depends on ipf_pkg
`timescale 1ns / 1ps

module ipf_cfg (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ipf_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    output ipf_pkg::t_cfg             o_cfg
);
    import ipf_pkg::*;

    logic r_filter_enable;
    logic n_filter_enable;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb begin
        n_filter_enable = r_filter_enable;
        if (wr_en && (paddr[2] == REG_FILTER_ENABLE)) begin
            n_filter_enable = pwdata[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_enable <= 1'b0;
        end else begin
            r_filter_enable <= n_filter_enable;
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_FILTER_ENABLE) begin
            prdata = {31'd0, r_filter_enable};
        end
    end

    assign o_cfg.filter_enable = r_filter_enable;

endmodule

[rtl/ipf_engine.sv]
// ipf_engine: command sequencer, rule table access and newest-first match scan
// depends on ipf_pkg, ipf_if and ipf_ram
`timescale 1ns / 1ps

module ipf_engine (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ipf_pkg::t_cfg i_cfg,
    ipf_in_if.sink        i_in,
    ipf_out_if.source     o_out
);
    import ipf_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]         r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [RULE_AW-1:0] r_idx, n_idx;
    logic               r_issue, n_issue;       // a read is still to be issued
    logic               r_pend, n_pend;         // read data arrives this cycle
    logic               r_pend_last, n_pend_last;
    t_pkt               r_pkt, n_pkt;
    logic               r_verdict, n_verdict;
    logic               r_status, n_status;
    logic               r_out_valid, n_out_valid;
    logic               r_out_verdict, n_out_verdict;
    logic               r_out_status, n_out_status;

    logic               accept;
    logic               ram_we;
    t_rule              wr_rule;
    logic [RULE_W-1:0]  ram_rdata;
    t_rule              rd_rule;
    logic               proto_ok, src_ok, dst_ok, port_ok, hit;
    logic               tcp_no_syn;

    assign i_in.ready = (r_state == ST_IDLE);
    assign accept     = i_in.valid && i_in.ready;

    assign wr_rule.src_ip   = i_in.src_ip;
    assign wr_rule.src_mask = i_in.src_mask;
    assign wr_rule.dst_ip   = i_in.dst_ip;
    assign wr_rule.dst_mask = i_in.dst_mask;
    assign wr_rule.src_port = i_in.src_port;
    assign wr_rule.dst_port = i_in.dst_port;
    assign wr_rule.protocol = i_in.protocol;
    assign wr_rule.drop     = i_in.drop_rule;

    ipf_ram #(
        .WIDTH (RULE_W),
        .DEPTH (MAX_RULES),
        .ADDR_W(RULE_AW)
    ) u_rule_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_count[RULE_AW-1:0]),
        .i_wdata(wr_rule),
        .i_raddr(r_idx),
        .o_rdata(ram_rdata)
    );

    // rule compare against the latched packet; zero in a rule field is a wildcard
    always_comb begin
        rd_rule  = t_rule'(ram_rdata);
        proto_ok = (rd_rule.protocol == 8'd0) || (rd_rule.protocol == r_pkt.protocol);
        src_ok   = (rd_rule.src_ip == 32'd0) ||
                   ((rd_rule.src_ip & rd_rule.src_mask) == (r_pkt.src_ip & rd_rule.src_mask));
        dst_ok   = (rd_rule.dst_ip == 32'd0) ||
                   ((rd_rule.dst_ip & rd_rule.dst_mask) == (r_pkt.dst_ip & rd_rule.dst_mask));
        port_ok  = 1'b1;
        if ((r_pkt.protocol == PROTO_TCP) || (r_pkt.protocol == PROTO_UDP)) begin
            port_ok = ((rd_rule.src_port == 16'd0) || (rd_rule.src_port == r_pkt.src_port)) &&
                      ((rd_rule.dst_port == 16'd0) || (rd_rule.dst_port == r_pkt.dst_port));
        end
        hit = proto_ok && src_ok && dst_ok && port_ok;
    end

    assign tcp_no_syn = (i_in.protocol == PROTO_TCP) && !i_in.tcp_flags[TCP_SYN_BIT];

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_idx         = r_idx;
        n_issue       = r_issue;
        n_pend        = r_pend;
        n_pend_last   = r_pend_last;
        n_pkt         = r_pkt;
        n_verdict     = r_verdict;
        n_status      = r_status;
        n_out_valid   = r_out_valid;
        n_out_verdict = r_out_verdict;
        n_out_status  = r_out_status;
        ram_we        = 1'b0;

        if (o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_verdict = VERDICT_FORWARD;
                    n_status  = STATUS_OK;
                    n_state   = ST_DONE;
                    case (i_in.command)
                        CMD_ADD: begin
                            if (r_count == CNT_W'(MAX_RULES)) begin
                                n_status = STATUS_FULL;
                            end else begin
                                ram_we  = 1'b1;
                                n_count = CNT_W'(r_count + 1'b1);
                            end
                        end
                        CMD_CLEAR: begin
                            n_count = '0;
                        end
                        CMD_CLASSIFY: begin
                            if (i_cfg.filter_enable && !tcp_no_syn && (r_count != '0)) begin
                                n_pkt.protocol = i_in.protocol;
                                n_pkt.src_ip   = i_in.src_ip;
                                n_pkt.dst_ip   = i_in.dst_ip;
                                n_pkt.src_port = i_in.src_port;
                                n_pkt.dst_port = i_in.dst_port;
                                n_idx          = RULE_AW'(r_count - 1'b1);
                                n_issue        = 1'b1;
                                n_pend         = 1'b0;
                                n_state        = ST_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // read of rule r_idx issued now, compare of the previous one below
                n_pend = r_issue;
                if (r_issue) begin
                    n_pend_last = (r_idx == '0);
                    if (r_idx == '0) begin
                        n_issue = 1'b0;
                    end else begin
                        n_idx = r_idx - 1'b1;
                    end
                end
                if (r_pend) begin
                    if (hit) begin
                        n_verdict = rd_rule.drop;
                        n_issue   = 1'b0;
                        n_pend    = 1'b0;
                        n_state   = ST_DONE;
                    end else if (r_pend_last) begin
                        n_verdict = VERDICT_FORWARD;
                        n_pend    = 1'b0;
                        n_state   = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid   = 1'b1;
                    n_out_verdict = r_verdict;
                    n_out_status  = r_status;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_issue     <= 1'b0;
            r_pend      <= 1'b0;
            r_pend_last <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_issue     <= n_issue;
            r_pend      <= n_pend;
            r_pend_last <= n_pend_last;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx         <= n_idx;
        r_pkt         <= n_pkt;
        r_verdict     <= n_verdict;
        r_status      <= n_status;
        r_out_verdict <= n_out_verdict;
        r_out_status  <= n_out_status;
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.verdict = r_out_verdict;
    assign o_out.status  = r_out_status;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_RULES))
        else $error("rule count above table size");

    a_scan_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_count != '0))
        else $error("scan running on an empty table");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_in.command == CMD_CLEAR)) |=> (r_count == '0))
        else $error("clear did not empty the table");

    a_full_add_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_in.command == CMD_ADD) && (r_count == CNT_W'(MAX_RULES)))
        |=> ($stable(r_count) && (r_status == STATUS_FULL)))
        else $error("add on a full table changed the count");

    a_write_idle_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> ((r_state == ST_IDLE) && !r_issue && !r_pend))
        else $error("rule write overlapped a scan");

endmodule

[rtl/ip_packet_rule_filter.sv]
// ip_packet_rule_filter: five-tuple first-match packet filter, top level
// depends on ipf_pkg, ipf_if, ipf_cfg, ipf_engine (and ipf_ram below it)
//
// usage:
//   i_in carries command items (add rule, clear rules, classify packet) and
//   o_out returns exactly one result item (verdict, status) per command.
//   an item is taken when valid and ready are both high at a clock edge.
//   the apb port holds filter_enable at byte address 0; write it only while
//   the block is idle.
// operation:
//   one item is in work at a time. add, clear and unused codes go from
//   acceptance straight to the done state and then to the output register.
//   classify scans the rule memory newest rule first, one rule per cycle
//   through a registered read port; disabled filtering, a tcp item without
//   syn or an empty table skip the scan and go straight to the done state.
//   the scan stops at the first matching rule.
// reset:
//   synchronous active-low i_rst_n empties the table and clears filter_enable;
//   rule memory contents are not cleared since only stored entries are read.
// stall:
//   a result waits in the output register while o_out.ready is low; the next
//   item is still taken and worked on, and it then holds until the slot frees.
`timescale 1ns / 1ps

module ip_packet_rule_filter (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ipf_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    ipf_in_if.sink                     i_in,
    ipf_out_if.source                  o_out
);
    import ipf_pkg::*;

    t_cfg cfg;

    ipf_cfg u_cfg (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready),
        .o_cfg  (cfg)
    );

    ipf_engine u_engine (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (cfg),
        .i_in   (i_in),
        .o_out  (o_out)
    );

endmodule
